### rtl/skst_pkg.sv
// Shared types and constants for the sorted key set table.
// Holds command and status codes, fixed result field widths and the scan result struct.
// No dependencies.
package skst_pkg;

   // Operation codes carried in the low bits of a request beat.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 5;
   localparam int COUNT_W    = 5;
   localparam int RSP_FLDS_W = STATUS_W + 1 + POS_W + COUNT_W;
   localparam int RSP_W      = ((RSP_FLDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_W - RSP_FLDS_W;

   // Outcome of one comparison step of the table walk.
   typedef struct packed {
      logic advance;  // entry is valid and smaller than the key
      logic hit;      // entry is valid and equal to the key
   } scan_result_type;

endpackage

### rtl/skst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the key store of the sorted key set table. No dependencies.
module skst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/skst_cmp.sv
// Shared compare unit of the sorted key set table walk.
// Compares one stored entry with the request key; uses skst_pkg for the result struct.
module skst_cmp
   import skst_pkg::*;
#(
   parameter int KEY_WIDTH = 16,
   parameter int CW = 5
) (
   input  logic signed [KEY_WIDTH-1:0] key,
   input  logic signed [KEY_WIDTH-1:0] entry,
   input  logic [CW-1:0]               idx,
   input  logic [CW-1:0]               count,
   output scan_result_type             result
);

   logic in_range;

   // Only entries below the current count hold keys.
   assign in_range       = idx < count;
   assign result.advance = in_range && (entry < key);
   assign result.hit     = in_range && (entry == key);

endmodule

### rtl/sorted_key_set_table.sv
// Sorted key set table: a bounded, ascending table of unique signed keys.
// Channels: the request stream (req_tvalid/req_tready/req_tdata) carries one
// command and one key per beat; the response stream (rsp_tvalid/rsp_tready/
// rsp_tdata) returns exactly one beat per request with status, found flag,
// position and the entry count after the operation.
// The block works on one request at a time. A single compare unit walks the
// key store from the lowest entry, one entry per cycle, until it meets the
// first key that is not smaller. Insert then moves the larger entries up one
// place and delete moves them down one place, one entry per cycle through the
// single write port of the store. A clear answers without a walk; a search
// answers when the walk stops; an insert walks, moves the larger entries up
// and writes the new key; a delete walks and moves the larger entries down.
// An insert of a present key or into a full table, and a delete of a missing
// key, answer when the walk stops. After the response handshake the block
// returns to idle and can take the next request.
// req_tready is high only while the block is idle. When the receiver stalls,
// the response beat holds and no new request is taken until it is taken.
// Reset (synchronous, active high) empties the table and returns to idle;
// the store itself is not cleared, since entries at or above the count are
// never used.
module sorted_key_set_table
   import skst_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_WIDTH = 16,
   localparam int REQ_W = ((CMD_W + KEY_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // cmd, key, zero padding
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // status, found, position, entry_count, zero padding
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SCAN = 6'b000010,
      S_PREP = 6'b000100,
      S_MOVE = 6'b001000,
      S_PUT  = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                occ_ff, occ_in;
   logic [CW-1:0]                mv_ff, mv_in;
   cmd_type                      cmd_ff, cmd_in;
   logic signed [KEY_WIDTH-1:0]  key_ff, key_in;
   status_type                   status_ff, status_in;
   logic                         found_ff, found_in;
   logic [POS_W-1:0]             pos_ff, pos_in;

   logic                         req_fire;
   cmd_type                      req_cmd;
   logic signed [KEY_WIDTH-1:0]  req_key;
   logic [CW-1:0]                idx_inc;
   logic [CW-1:0]                mv_inc;
   logic [CW-1:0]                mv_dec;
   logic [CW-1:0]                mv_inc2;
   logic [CW-1:0]                mv_dec2;
   logic [CW-1:0]                occ_dec;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [KEY_WIDTH-1:0]         ram_wdata;
   logic [AW-1:0]                ram_raddr;
   logic [KEY_WIDTH-1:0]         ram_rdata;
   scan_result_type              scan;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_key    = req_tdata[CMD_W +: KEY_WIDTH];

   assign idx_inc = idx_ff + CW'(1);
   assign mv_inc  = mv_ff + CW'(1);
   assign mv_dec  = mv_ff - CW'(1);
   assign mv_inc2 = mv_ff + CW'(2);
   assign mv_dec2 = mv_ff - CW'(2);
   assign occ_dec = occ_ff - CW'(1);

   skst_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   skst_cmp #(
      .KEY_WIDTH (KEY_WIDTH),
      .CW        (CW)
   ) u_cmp (
      .key    (key_ff),
      .entry  (ram_rdata),
      .idx    (idx_ff),
      .count  (occ_ff),
      .result (scan)
   );

   // Sequencer. The store read is registered, so the address for each read is
   // issued by the state before the one that consumes the data.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      occ_in    = occ_ff;
      mv_in     = mv_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      status_in = status_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      ram_we    = 1'b0;
      ram_waddr = mv_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               idx_in    = '0;
               status_in = STAT_OK;
               found_in  = 1'b0;
               pos_in    = '0;
               if (req_cmd == CMD_CLEAR) begin
                  occ_in   = '0;
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan.advance) begin
               idx_in    = idx_inc;
               ram_raddr = idx_inc[AW-1:0];
            end else begin
               case (cmd_ff)
                  CMD_SEARCH: begin
                     found_in  = scan.hit;
                     pos_in    = POS_W'(idx_ff);
                     status_in = scan.hit ? STAT_OK : STAT_MISS;
                     state_in  = S_RESP;
                  end
                  CMD_INSERT: begin
                     if (scan.hit) begin
                        status_in = STAT_MISS;
                        state_in  = S_RESP;
                     end else if (occ_ff >= CW'(TABLE_DEPTH)) begin
                        status_in = STAT_FULL;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_PREP;
                     end
                  end
                  default: begin
                     if (scan.hit) begin
                        state_in = S_PREP;
                     end else begin
                        status_in = STAT_MISS;
                        state_in  = S_RESP;
                     end
                  end
               endcase
            end
         end
         S_PREP: begin
            if (cmd_ff == CMD_INSERT) begin
               // Move entries idx..occ-1 up by one, starting from the top.
               mv_in     = occ_ff;
               ram_raddr = occ_dec[AW-1:0];
               state_in  = (occ_ff == idx_ff) ? S_PUT : S_MOVE;
            end else begin
               // Move entries idx+1..occ-1 down by one, starting at idx.
               mv_in     = idx_ff;
               ram_raddr = idx_inc[AW-1:0];
               if (idx_inc >= occ_ff) begin
                  occ_in   = occ_dec;
                  state_in = S_RESP;
               end else begin
                  state_in = S_MOVE;
               end
            end
         end
         S_MOVE: begin
            ram_we = 1'b1;
            if (cmd_ff == CMD_INSERT) begin
               ram_raddr = mv_dec2[AW-1:0];
               mv_in     = mv_dec;
               if (mv_dec == idx_ff) begin
                  state_in = S_PUT;
               end
            end else begin
               ram_raddr = mv_inc2[AW-1:0];
               mv_in     = mv_inc;
               if (mv_inc2 >= occ_ff) begin
                  occ_in   = occ_dec;
                  state_in = S_RESP;
               end
            end
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = key_ff;
            occ_in    = occ_ff + CW'(1);
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      mv_ff     <= mv_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
   end

   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, COUNT_W'(occ_ff), pos_ff, found_ff, status_ff};

   // The count never passes the table depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // Only one request is in flight: no request is taken while a response waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while response pending");

   // A clear answers in the next cycle with an empty table.
   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_cmd == CMD_CLEAR)) |=> (rsp_tvalid && (occ_ff == '0)))
      else $error("clear did not empty the table");

   // Table full is only reported when every entry is in use.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status_ff == STAT_FULL)) |-> (occ_ff == CW'(TABLE_DEPTH)))
      else $error("table full reported on a table with room");

   // The store is written only while moving entries or placing a new key.
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == S_MOVE) || (state_ff == S_PUT)))
      else $error("store written outside an update");

endmodule
